// File: src/direction_to_latlong_texel_macros.svh
// Assertion macros shared by the texel addressing block
`ifndef DIRECTION_TO_LATLONG_TEXEL_MACROS_SVH
`define DIRECTION_TO_LATLONG_TEXEL_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset
`define DTL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset
`define DTL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/dtl_pkg.sv
// ----------------------------------------------------------------------------
// dtl_pkg
// Types and constants of the lat-long texel addressing pipeline.
// ----------------------------------------------------------------------------
package dtl_pkg;

    localparam int SQRT_STEPS   = 16;
    localparam int CORDIC_STEPS = 30;
    localparam int CW           = 34;   // CORDIC datapath width

    localparam logic REG_MAP_WIDTH  = 1'b0;
    localparam logic REG_MAP_HEIGHT = 1'b1;

    localparam logic signed [CW-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [CW-1:0] HALF_TURN    = 34'sd2147483648;

    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
    } t_dir_in;

    typedef struct packed {
        logic [11:0] texel_col;
        logic [10:0] texel_row;
    } t_texel_out;

    typedef struct packed {
        logic        vld;
        logic [31:0] v;
        logic [31:0] root;
        t_dir_in     dir;
    } t_sqrt;

    typedef struct packed {
        logic                 vld;
        logic                 zero;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] acc;
    } t_cordic;

    // Scale to Q1.29 and rotate into the right half plane
    function automatic t_cordic cordic_prep(input logic signed [16:0] yy,
                                            input logic signed [16:0] xx);
        t_cordic c;
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        sx = CW'(xx) <<< 14;
        sy = CW'(yy) <<< 14;
        c.vld  = 1'b0;
        c.zero = (xx == 17'sd0) && (yy == 17'sd0);
        c.x    = sx;
        c.y    = sy;
        c.acc  = '0;
        if (sx < 0) begin
            if (sy >= 0) begin
                c.x   = sy;
                c.y   = -sx;
                c.acc = QUARTER_TURN;
            end else begin
                c.x   = -sy;
                c.y   = sx;
                c.acc = -QUARTER_TURN;
            end
        end
        return c;
    endfunction

endpackage

// File: src/dtl_sqrt_cell.sv
// ----------------------------------------------------------------------------
// dtl_sqrt_cell
// One bit pair of the restoring integer square root, registered.
// ----------------------------------------------------------------------------
module dtl_sqrt_cell
    import dtl_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_sqrt i_cell,
    output t_sqrt o_cell
);

    localparam logic [32:0] BIT = 33'd1 << (30 - 2 * STEP);

    t_sqrt       r_cell;
    t_sqrt       n_cell;
    logic [32:0] trial;

    // Try to subtract root + bit, shift the root
    always_comb begin
        n_cell = i_cell;
        trial  = {1'b0, i_cell.root} + BIT;
        if ({1'b0, i_cell.v} >= trial) begin
            n_cell.v    = 32'({1'b0, i_cell.v} - trial);
            n_cell.root = 32'({1'b0, i_cell.root >> 1} + BIT);
        end else begin
            n_cell.root = i_cell.root >> 1;
        end
    end

    // Hand the request on to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else begin
            r_cell.vld <= n_cell.vld;
        end
        r_cell.v    <= n_cell.v;
        r_cell.root <= n_cell.root;
        r_cell.dir  <= n_cell.dir;
    end

    assign o_cell = r_cell;

endmodule

// File: src/dtl_cordic_cell.sv
// ----------------------------------------------------------------------------
// dtl_cordic_cell
// One vectoring micro-rotation of the CORDIC angle unit, registered.
// ----------------------------------------------------------------------------
module dtl_cordic_cell
    import dtl_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cordic i_cell,
    output t_cordic o_cell
);

    localparam logic signed [CW-1:0] ANG = CW'(ATAN_TAB[STEP]);

    t_cordic              r_cell;
    t_cordic              n_cell;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    // Rotate toward the x axis and accumulate the angle
    always_comb begin
        n_cell = i_cell;
        dx     = i_cell.y >>> STEP;
        dy     = i_cell.x >>> STEP;
        if (i_cell.y > 0) begin
            n_cell.x   = i_cell.x + dx;
            n_cell.y   = i_cell.y - dy;
            n_cell.acc = i_cell.acc + ANG;
        end else begin
            n_cell.x   = i_cell.x - dx;
            n_cell.y   = i_cell.y + dy;
            n_cell.acc = i_cell.acc - ANG;
        end
    end

    // Hand the request on to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else begin
            r_cell.vld <= n_cell.vld;
        end
        r_cell.zero <= n_cell.zero;
        r_cell.x    <= n_cell.x;
        r_cell.y    <= n_cell.y;
        r_cell.acc  <= n_cell.acc;
    end

    assign o_cell = r_cell;

endmodule

// File: src/direction_to_latlong_texel.sv
// Pipeline from start to o_strobe: 1 square, 16 root, 1 prep, 30 CORDIC and
// 3 scale/clamp stages. Throughput: one request per cycle; busy stays low,
// every stage advances each cycle. Results cannot be stalled and appear for
// one cycle on o_strobe. Reset (synchronous, active low) flushes all valid
// bits and loads map size 1024 x 512.
// ----------------------------------------------------------------------------
// direction_to_latlong_texel
// Unit direction to equirectangular texel column and row.
// ----------------------------------------------------------------------------
`include "direction_to_latlong_texel_macros.svh"

module direction_to_latlong_texel
    import dtl_pkg::*;
#(
    parameter int ANGLE_BITS = 18
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_dir_in     i_dir,
    output logic        o_strobe,
    output t_texel_out  o_texel,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [12:0] i_cfg_data
);

    localparam int FW = ANGLE_BITS + 1;
    localparam int SH = 32 - ANGLE_BITS;

    logic [12:0] r_width;
    logic [11:0] r_height;

    t_sqrt   s_sq  [SQRT_STEPS+1];
    t_cordic c_az  [CORDIC_STEPS+1];
    t_cordic c_pol [CORDIC_STEPS+1];

    t_sqrt   r_sq0;
    t_cordic r_prep_az;
    t_cordic r_prep_pol;

    logic [FW-1:0]    r_faz;
    logic [FW-1:0]    r_fpol;
    logic             r_nrm_vld;
    logic [FW+12:0]   r_pcol;
    logic [FW+11:0]   r_prow;
    logic             r_mul_vld;
    t_texel_out       r_out;
    logic             r_strobe;

    logic signed [31:0] ysq;
    t_cordic            n_az;
    t_cordic            n_pol;
    logic signed [CW-1:0] az_sat;
    logic signed [CW-1:0] pol_sat;
    logic [32:0]        az_off;
    logic [13:0]        col_idx;
    logic [12:0]        row_idx;
    logic [13:0]        col_clamp;
    logic [12:0]        row_clamp;

    assign busy = 1'b0;

    // Hold the map size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 13'd1024;
            r_height <= 12'd512;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MAP_WIDTH:  r_width  <= i_cfg_data;
                REG_MAP_HEIGHT: r_height <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // Square y and form the radicand 1 - y^2
    assign ysq = 32'(i_dir.dir_y) * 32'(i_dir.dir_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq0.vld <= 1'b0;
        end else begin
            r_sq0.vld <= start & ~busy;
        end
        r_sq0.v    <= 32'h4000_0000 - 32'(ysq);
        r_sq0.root <= '0;
        r_sq0.dir  <= i_dir;
    end

    assign s_sq[0] = r_sq0;

    // Advance through the root cell chain
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        dtl_sqrt_cell #(.STEP(k)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_cell (s_sq[k]),
            .o_cell (s_sq[k+1])
        );
    end

    // Prepare both vectors for the angle chains
    always_comb begin
        n_az  = cordic_prep(17'(s_sq[SQRT_STEPS].dir.dir_z),
                            17'(s_sq[SQRT_STEPS].dir.dir_x));
        n_pol = cordic_prep(s_sq[SQRT_STEPS].root[16:0],
                            17'(s_sq[SQRT_STEPS].dir.dir_y));
        n_az.vld  = s_sq[SQRT_STEPS].vld;
        n_pol.vld = s_sq[SQRT_STEPS].vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_az.vld  <= 1'b0;
            r_prep_pol.vld <= 1'b0;
        end else begin
            r_prep_az.vld  <= n_az.vld;
            r_prep_pol.vld <= n_pol.vld;
        end
        r_prep_az.zero  <= n_az.zero;
        r_prep_az.x     <= n_az.x;
        r_prep_az.y     <= n_az.y;
        r_prep_az.acc   <= n_az.acc;
        r_prep_pol.zero <= n_pol.zero;
        r_prep_pol.x    <= n_pol.x;
        r_prep_pol.y    <= n_pol.y;
        r_prep_pol.acc  <= n_pol.acc;
    end

    assign c_az[0]  = r_prep_az;
    assign c_pol[0] = r_prep_pol;

    // Advance through the azimuth and polar CORDIC chains
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        dtl_cordic_cell #(.STEP(k)) u_az (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_cell (c_az[k]),
            .o_cell (c_az[k+1])
        );
        dtl_cordic_cell #(.STEP(k)) u_pol (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_cell (c_pol[k]),
            .o_cell (c_pol[k+1])
        );
    end

    // Saturate the angles and normalize to ANGLE_BITS fractions
    always_comb begin
        az_sat = c_az[CORDIC_STEPS].acc;
        if (az_sat > HALF_TURN) az_sat = HALF_TURN;
        if (az_sat < -HALF_TURN) az_sat = -HALF_TURN;
        if (c_az[CORDIC_STEPS].zero) az_sat = '0;
        pol_sat = c_pol[CORDIC_STEPS].acc;
        if (pol_sat > HALF_TURN) pol_sat = HALF_TURN;
        if (pol_sat < 0) pol_sat = '0;
        if (c_pol[CORDIC_STEPS].zero) pol_sat = '0;
        az_off = 33'(HALF_TURN - az_sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nrm_vld <= 1'b0;
            r_mul_vld <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_nrm_vld <= c_az[CORDIC_STEPS].vld;
            r_mul_vld <= r_nrm_vld;
            r_strobe  <= r_mul_vld;
        end
        r_faz  <= FW'(az_off >> SH);
        r_fpol <= FW'(pol_sat[32:0] >> SH);
        r_pcol <= (FW+13)'(r_faz) * (FW+13)'(r_width);
        r_prow <= (FW+12)'(r_fpol) * (FW+12)'(r_height);
        r_out  <= {col_clamp[11:0], row_clamp[10:0]};
    end

    // Clamp the indexes to the map and to the field range
    always_comb begin
        col_idx = 14'(r_pcol >> ANGLE_BITS);
        row_idx = 13'(r_prow >> ANGLE_BITS);
        col_clamp = col_idx;
        row_clamp = row_idx;
        if (col_clamp > 14'(r_width) - 14'd1) col_clamp = 14'(r_width) - 14'd1;
        if (col_clamp > 14'd4095) col_clamp = 14'd4095;
        if (r_width == 13'd0) col_clamp = '0;
        if (row_clamp > 13'(r_height) - 13'd1) row_clamp = 13'(r_height) - 13'd1;
        if (row_clamp > 13'd2047) row_clamp = 13'd2047;
        if (r_height == 12'd0) row_clamp = '0;
    end

    assign o_strobe = r_strobe;
    assign o_texel  = r_out;

    `DTL_ASSERT_NEXT(a_accept_enters, start && !busy, r_sq0.vld, "accepted request lost")
    `DTL_ASSERT_NEXT(a_strobe_follows, r_mul_vld, o_strobe, "result strobe missing")
    `DTL_ASSERT_NEXT(a_no_spurious, !r_mul_vld, !o_strobe, "result strobe without request")
    `DTL_ASSERT_NOW(a_col_in_map, o_strobe && $past(r_width) != 13'd0, {1'b0, o_texel.texel_col} < $past(r_width), "column beyond map width")

endmodule

// File: verif/direction_to_latlong_texel_tb.sv
// ----------------------------------------------------------------------------
// direction_to_latlong_texel_tb
// Self-checking bench for the lat-long texel addressing block: it drives
// direction requests, predicts column and row with its own CORDIC and root
// model, and checks every strobed result in order across several map sizes.
// ----------------------------------------------------------------------------
module direction_to_latlong_texel_tb;
    import dtl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS   = 18;
    localparam int DRAIN_WAIT  = 64;
    localparam longint HALF_T  = 64'sd2147483648;
    localparam longint QUART_T = 64'sd1073741824;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_dir_in     i_dir;
    logic        o_strobe;
    t_texel_out  o_texel;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [12:0] i_cfg_data;

    longint unsigned map_cols;
    longint unsigned map_rows;
    t_texel_out      texel_fifo[$];
    int              err_count;
    bit              gaps_on;

    direction_to_latlong_texel dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_dir      (i_dir),
        .o_strobe   (o_strobe),
        .o_texel    (o_texel),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case results never drain
    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    // Integer square root by digit pairs
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 30;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Binary angle of (x, y), 2^32 per turn, saturated to a half turn
    function automatic longint binary_angle(input longint yv, input longint xv);
        longint acc;
        longint t;
        longint dx;
        longint dy;
        acc = 0;
        if (xv == 0 && yv == 0) return 0;
        xv = xv * 16384;
        yv = yv * 16384;
        if (xv < 0) begin
            t = xv;
            if (yv >= 0) begin
                xv = yv;
                yv = -t;
                acc = QUART_T;
            end else begin
                xv = -yv;
                yv = t;
                acc = -QUART_T;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv > 0) begin
                xv = xv + dx;
                yv = yv - dy;
                acc = acc + longint'(ATAN_TAB[i]);
            end else begin
                xv = xv - dx;
                yv = yv + dy;
                acc = acc - longint'(ATAN_TAB[i]);
            end
        end
        if (acc > HALF_T) acc = HALF_T;
        if (acc < -HALF_T) acc = -HALF_T;
        return acc;
    endfunction

    // Fraction times size, clamped to the last index and the field width
    function automatic longint unsigned to_index(input longint unsigned frac,
                                                 input longint unsigned size,
                                                 input longint unsigned cap);
        longint unsigned idx;
        idx = (frac * size) >> FRAC_BITS;
        if (size == 0) return 0;
        if (idx > size - 1) idx = size - 1;
        if (idx > cap) idx = cap;
        return idx;
    endfunction

    function automatic t_texel_out predict_texel(input t_dir_in d);
        t_texel_out      r;
        longint          xv;
        longint          yv;
        longint          zv;
        longint          az;
        longint          pol;
        longint unsigned s;
        longint unsigned faz;
        longint unsigned fpol;
        xv  = longint'(d.dir_x);
        yv  = longint'(d.dir_y);
        zv  = longint'(d.dir_z);
        s   = int_sqrt(unsigned'(QUART_T - yv * yv));
        az  = binary_angle(zv, xv);
        pol = binary_angle(longint'(s), yv);
        if (pol < 0) pol = 0;
        faz  = unsigned'(HALF_T - az) >> (32 - FRAC_BITS);
        fpol = unsigned'(pol) >> (32 - FRAC_BITS);
        r.texel_col = 12'(to_index(faz, map_cols, 4095));
        r.texel_row = 11'(to_index(fpol, map_rows, 2047));
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("tb: mismatch at %0t: %s", $realtime, msg);
    endtask

    // Check each strobed result against the oldest prediction
    always @(negedge i_clk) begin
        t_texel_out exp_t;
        if (i_rst_n && o_strobe) begin
            if (texel_fifo.size() == 0) begin
                report_mismatch("result with no request pending");
            end else begin
                exp_t = texel_fifo.pop_front();
                if (o_texel.texel_col !== exp_t.texel_col)
                    report_mismatch($sformatf("col got %0d want %0d",
                                    o_texel.texel_col, exp_t.texel_col));
                if (o_texel.texel_row !== exp_t.texel_row)
                    report_mismatch($sformatf("row got %0d want %0d",
                                    o_texel.texel_row, exp_t.texel_row));
            end
        end
    end

    // Send one request, then maybe drop start before the next one
    task automatic send_dir(input t_dir_in d);
        i_dir <= d;
        start <= 1'b1;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        texel_fifo.push_back(predict_texel(d));
        if (gaps_on && $urandom_range(0, 99) < 41) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_xyz(input int xv, input int yv, input int zv);
        t_dir_in d;
        d.dir_x = 16'(xv);
        d.dir_y = 16'(yv);
        d.dir_z = 16'(zv);
        send_dir(d);
    endtask

    // Hold off until every pending result has come back
    task automatic drain;
        start <= 1'b0;
        wait (texel_fifo.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_size(input logic idx, input logic [12:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == REG_MAP_WIDTH) map_cols = val;
        else map_rows = val & 13'h0FFF;
    endtask

    task automatic set_map(input logic [12:0] w, input logic [12:0] h);
        drain();
        write_size(REG_MAP_WIDTH, w);
        write_size(REG_MAP_HEIGHT, h);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] rand_comp;
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 15)) - 16'd8;
            1: return ($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
            2: return 16'($urandom_range(0, 511)) - 16'd256;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++)
            send_xyz(rand_comp(), rand_comp(), rand_comp());
    endtask

    // Axes, poles, extremes and the zero azimuth at the current map size
    task automatic test_directed;
        send_xyz(0, 0, 0);
        send_xyz(0, 32767, 0);
        send_xyz(0, -32768, 0);
        send_xyz(32767, 0, 0);
        send_xyz(-32768, 0, 0);
        send_xyz(0, 0, 32767);
        send_xyz(0, 0, -32768);
        send_xyz(-32768, 0, 1);
        send_xyz(-32768, 0, -1);
        send_xyz(-32768, -32768, -32768);
        send_xyz(32767, 32767, 32767);
        send_xyz(-32768, 32767, 32767);
        send_xyz(1, 1, 1);
        send_xyz(-1, -1, -1);
        send_xyz(23170, 0, 23170);
        send_xyz(-23170, 23170, -23170);
    endtask

    // Edge sizes: one texel, largest legal, zero and beyond range
    task automatic test_size_extremes;
        set_map(13'd1, 13'd1);
        test_directed();
        set_map(13'd4096, 13'd2048);
        test_directed();
        set_map(13'd0, 13'd0);
        send_random(20);
        set_map(13'h1FFF, 13'h1FFF);
        test_directed();
        send_random(20);
    endtask

    // Random sizes with random directions, one phase without gaps
    task automatic test_random_maps;
        for (int ph = 0; ph < 6; ph++) begin
            set_map(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 2048)));
            gaps_on = (ph != 2);
            send_random(270);
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        start      = 1'b0;
        i_dir      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_MAP_WIDTH;
        i_cfg_data = '0;
        i_rst_n    = 1'b0;
        map_cols   = 1024;
        map_rows   = 512;
        err_count  = 0;
        gaps_on    = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_size_extremes();
        test_random_maps();

        drain();
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
